/* rtl/assert_macros.svh */
// Assertion macros for the source token lexer RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define STL_ASSERT_HOLDS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: check failed");

// When the antecedent holds, the consequent holds at the next clock edge.
`define STL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define STL_ASSERT_HOLDS(name, clk, rst, expr)
`define STL_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* rtl/stl_pkg.sv */
// Types and constants of the source token lexer.
// Used by the scanner, the result queue and the top level.
package stl_pkg;

   // Token kinds.
   localparam logic [5:0] KIND_END    = 6'd0;
   localparam logic [5:0] KIND_SEMI   = 6'd1;
   localparam logic [5:0] KIND_IDENT  = 6'd2;
   localparam logic [5:0] KIND_IF     = 6'd3;
   localparam logic [5:0] KIND_ELSE   = 6'd4;
   localparam logic [5:0] KIND_WHILE  = 6'd5;
   localparam logic [5:0] KIND_TYPE   = 6'd6;
   localparam logic [5:0] KIND_PLUS   = 6'd7;
   localparam logic [5:0] KIND_MINUS  = 6'd8;
   localparam logic [5:0] KIND_STAR   = 6'd9;
   localparam logic [5:0] KIND_SLASH  = 6'd10;
   localparam logic [5:0] KIND_PCT    = 6'd11;
   localparam logic [5:0] KIND_COMMA  = 6'd12;
   localparam logic [5:0] KIND_ASSIGN = 6'd13;
   localparam logic [5:0] KIND_EQ     = 6'd14;
   localparam logic [5:0] KIND_NE     = 6'd15;
   localparam logic [5:0] KIND_GE     = 6'd16;
   localparam logic [5:0] KIND_GT     = 6'd17;
   localparam logic [5:0] KIND_LE     = 6'd18;
   localparam logic [5:0] KIND_LT     = 6'd19;
   localparam logic [5:0] KIND_NOT    = 6'd20;
   localparam logic [5:0] KIND_AND    = 6'd21;
   localparam logic [5:0] KIND_OR     = 6'd22;
   localparam logic [5:0] KIND_LPAREN = 6'd23;
   localparam logic [5:0] KIND_RPAREN = 6'd24;
   localparam logic [5:0] KIND_LBRACE = 6'd25;
   localparam logic [5:0] KIND_RBRACE = 6'd26;
   localparam logic [5:0] KIND_LBRACK = 6'd27;
   localparam logic [5:0] KIND_RBRACK = 6'd28;
   localparam logic [5:0] KIND_INT    = 6'd29;
   localparam logic [5:0] KIND_FLOAT  = 6'd30;
   localparam logic [5:0] KIND_STRING = 6'd31;
   localparam logic [5:0] KIND_CHAR   = 6'd32;

   // Error codes.
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_UNSUP_OP    = 3'd1;
   localparam logic [2:0] ERR_NEWLINE_LIT = 3'd2;
   localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd3;
   localparam logic [2:0] ERR_EOF_LIT     = 3'd4;
   localparam logic [2:0] ERR_CHAR_LONG   = 3'd5;
   localparam logic [2:0] ERR_BAD_CHAR    = 3'd6;

   // Special characters.
   localparam logic [7:0] CH_COMMENT   = 8'h3F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // Keyword prefixes, first byte in the low bits.
   localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
   localparam logic [39:0] KW_ELSE  = 40'h00_6573_6C65;
   localparam logic [39:0] KW_WHILE = 40'h65_6C69_6877;
   localparam logic [39:0] KW_U8    = 40'h00_0000_3875;
   localparam logic [39:0] KW_I64   = 40'h00_0034_3669;
   localparam logic [39:0] KW_F64   = 40'h00_0034_3666;

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int CNT_W     = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [2:0]  error_code;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

endpackage

/* rtl/stl_if.sv */
// Request and response channel interfaces of the source token lexer.
// Valid/ready handshake; no package dependency.
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [2:0]  error_code;
   logic [15:0] start_line;
   logic [15:0] start_column;
   logic [15:0] token_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output error_code, output start_line,
                   output start_column, output token_length, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input error_code, input start_line,
                 input start_column, input token_length, input last_of_run,
                 output ready);
endinterface

/* rtl/stl_scan.sv */
// Lexer scan state and per-byte next-state logic; produces up to two results per step.
// Depends on stl_pkg.
module stl_scan #(
   parameter int POS_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_valid,
   input  logic [7:0]      step_byte,
   input  logic            step_eot,
   output logic [1:0]      res_n,
   output stl_pkg::rsp_type res0,
   output stl_pkg::rsp_type res1
);

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_COMMENT, MODE_IDENT, MODE_INT, MODE_FLOAT,
      MODE_OP2, MODE_LIT, MODE_ESC, MODE_FAILED
   } mode_type;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   mode_type            mode_ff, mode_in;
   logic [7:0]          pend_ff, pend_in;
   logic [39:0]         prefix_ff, prefix_in;
   logic                qdbl_ff, qdbl_in;
   logic                lsb_ff, lsb_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] col_ff, col_in;
   logic [POS_BITS-1:0] tline_ff, tline_in;
   logic [POS_BITS-1:0] tcol_ff, tcol_in;
   logic [15:0]         cnt_ff, cnt_in;

   logic                ea_v, eb_v, do_start;
   stl_pkg::rsp_type    ea, eb;
   logic [5:0]          word_kind, pair_kind, lone_kind, start_kind;
   logic [7:0]          delim;

   function automatic logic [15:0] pos_out(input logic [32:0] p);
      if (p >= 33'd65535) begin
         pos_out = 16'hFFFF;
      end else begin
         pos_out = 16'(p + 33'd1);
      end
   endfunction

   function automatic stl_pkg::rsp_type mk(input logic [5:0] kind, input logic [2:0] err,
                                           input logic [32:0] ln, input logic [32:0] cl,
                                           input logic [15:0] len);
      stl_pkg::rsp_type r;
      r.token_kind   = kind;
      r.error_code   = err;
      r.start_line   = pos_out(ln);
      r.start_column = pos_out(cl);
      r.token_length = len;
      r.last_of_run  = 1'b0;
      mk = r;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c >= 8'h30 && c <= 8'h39;
   endfunction

   // Kind of a byte that is a complete token on its own, else KIND_END.
   function automatic logic [5:0] single_kind(input logic [7:0] c);
      case (c)
         8'h3B:   single_kind = stl_pkg::KIND_SEMI;
         8'h2B:   single_kind = stl_pkg::KIND_PLUS;
         8'h2D:   single_kind = stl_pkg::KIND_MINUS;
         8'h2A:   single_kind = stl_pkg::KIND_STAR;
         8'h2F:   single_kind = stl_pkg::KIND_SLASH;
         8'h25:   single_kind = stl_pkg::KIND_PCT;
         8'h2C:   single_kind = stl_pkg::KIND_COMMA;
         8'h28:   single_kind = stl_pkg::KIND_LPAREN;
         8'h29:   single_kind = stl_pkg::KIND_RPAREN;
         8'h7B:   single_kind = stl_pkg::KIND_LBRACE;
         8'h7D:   single_kind = stl_pkg::KIND_RBRACE;
         8'h5B:   single_kind = stl_pkg::KIND_LBRACK;
         8'h5D:   single_kind = stl_pkg::KIND_RBRACK;
         default: single_kind = stl_pkg::KIND_END;
      endcase
   endfunction

   // Keyword and word classification from the registered prefix.
   always_comb begin
      if (mode_ff == MODE_INT) begin
         word_kind = stl_pkg::KIND_INT;
      end else if (mode_ff == MODE_FLOAT) begin
         word_kind = stl_pkg::KIND_FLOAT;
      end else if (cnt_ff == 16'd2 && prefix_ff == stl_pkg::KW_IF) begin
         word_kind = stl_pkg::KIND_IF;
      end else if (cnt_ff == 16'd4 && prefix_ff == stl_pkg::KW_ELSE) begin
         word_kind = stl_pkg::KIND_ELSE;
      end else if (cnt_ff == 16'd5 && prefix_ff == stl_pkg::KW_WHILE) begin
         word_kind = stl_pkg::KIND_WHILE;
      end else if ((cnt_ff == 16'd2 && prefix_ff == stl_pkg::KW_U8) ||
                   (cnt_ff == 16'd3 && prefix_ff == stl_pkg::KW_I64) ||
                   (cnt_ff == 16'd3 && prefix_ff == stl_pkg::KW_F64)) begin
         word_kind = stl_pkg::KIND_TYPE;
      end else begin
         word_kind = stl_pkg::KIND_IDENT;
      end
   end

   // Two-character operator of the pending byte and this byte, and the pending byte's lone kind.
   always_comb begin
      pair_kind = stl_pkg::KIND_END;
      if (step_byte == 8'h3D) begin
         case (pend_ff)
            8'h3D:   pair_kind = stl_pkg::KIND_EQ;
            8'h21:   pair_kind = stl_pkg::KIND_NE;
            8'h3E:   pair_kind = stl_pkg::KIND_GE;
            8'h3C:   pair_kind = stl_pkg::KIND_LE;
            default: pair_kind = stl_pkg::KIND_END;
         endcase
      end else if (step_byte == 8'h26 && pend_ff == 8'h26) begin
         pair_kind = stl_pkg::KIND_AND;
      end else if (step_byte == 8'h7C && pend_ff == 8'h7C) begin
         pair_kind = stl_pkg::KIND_OR;
      end
      case (pend_ff)
         8'h3D:   lone_kind = stl_pkg::KIND_ASSIGN;
         8'h21:   lone_kind = stl_pkg::KIND_NOT;
         8'h3E:   lone_kind = stl_pkg::KIND_GT;
         8'h3C:   lone_kind = stl_pkg::KIND_LT;
         default: lone_kind = stl_pkg::KIND_END;
      endcase
   end

   assign start_kind = single_kind(step_byte);
   assign delim      = qdbl_ff ? 8'h22 : 8'h27;

   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      prefix_in = prefix_ff;
      qdbl_in   = qdbl_ff;
      lsb_in    = lsb_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      cnt_in    = cnt_ff;
      ea_v      = 1'b0;
      eb_v      = 1'b0;
      ea        = mk(stl_pkg::KIND_END, stl_pkg::ERR_NONE, 33'(line_ff), 33'(col_ff), 16'd0);
      eb        = ea;
      do_start  = 1'b0;

      if (step_eot) begin
         // Flush whatever is pending, then the end result, then back to reset values.
         case (mode_ff)
            MODE_IDENT, MODE_INT, MODE_FLOAT: begin
               ea_v = 1'b1;
               ea   = mk(word_kind, stl_pkg::ERR_NONE, 33'(tline_ff), 33'(tcol_ff), cnt_ff);
            end
            MODE_OP2: begin
               ea_v = 1'b1;
               if (lone_kind != stl_pkg::KIND_END) begin
                  ea = mk(lone_kind, stl_pkg::ERR_NONE, 33'(tline_ff), 33'(tcol_ff), 16'd1);
               end else begin
                  ea = mk(stl_pkg::KIND_END, stl_pkg::ERR_UNSUP_OP, 33'(tline_ff),
                          33'(tcol_ff), 16'd0);
               end
            end
            MODE_LIT, MODE_ESC: begin
               ea_v = 1'b1;
               ea   = mk(stl_pkg::KIND_END, stl_pkg::ERR_EOF_LIT, 33'(line_ff),
                         33'(col_ff), 16'd0);
            end
            default: ;
         endcase
         eb_v      = 1'b1;
         mode_in   = MODE_IDLE;
         pend_in   = '0;
         prefix_in = '0;
         qdbl_in   = 1'b0;
         lsb_in    = 1'b0;
         line_in   = '0;
         col_in    = '0;
         tline_in  = '0;
         tcol_in   = '0;
         cnt_in    = '0;
      end else begin
         case (mode_ff)
            MODE_IDLE: do_start = 1'b1;
            MODE_COMMENT: begin
               if (step_byte == 8'h0A) begin
                  if (line_in != POS_MAX) line_in = line_in + 1'b1;
                  col_in  = '0;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_alpha(step_byte) || is_digit(step_byte)) begin
                  if (cnt_ff < 16'd5) prefix_in[{cnt_ff[2:0], 3'b000} +: 8] = step_byte;
                  if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 1'b1;
                  if (col_in != POS_MAX) col_in = col_in + 1'b1;
               end else begin
                  ea_v     = 1'b1;
                  ea       = mk(word_kind, stl_pkg::ERR_NONE, 33'(tline_ff), 33'(tcol_ff),
                                cnt_ff);
                  mode_in  = MODE_IDLE;
                  do_start = 1'b1;
               end
            end
            MODE_INT, MODE_FLOAT: begin
               if (is_digit(step_byte) || (step_byte == 8'h2E && mode_ff == MODE_INT)) begin
                  if (step_byte == 8'h2E) mode_in = MODE_FLOAT;
                  if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 1'b1;
                  if (col_in != POS_MAX) col_in = col_in + 1'b1;
               end else begin
                  ea_v     = 1'b1;
                  ea       = mk(word_kind, stl_pkg::ERR_NONE, 33'(tline_ff), 33'(tcol_ff),
                                cnt_ff);
                  mode_in  = MODE_IDLE;
                  do_start = 1'b1;
               end
            end
            MODE_OP2: begin
               ea_v = 1'b1;
               if (pair_kind != stl_pkg::KIND_END) begin
                  ea      = mk(pair_kind, stl_pkg::ERR_NONE, 33'(tline_ff), 33'(tcol_ff),
                               16'd2);
                  if (col_in != POS_MAX) col_in = col_in + 1'b1;
                  mode_in = MODE_IDLE;
               end else if (lone_kind != stl_pkg::KIND_END) begin
                  ea       = mk(lone_kind, stl_pkg::ERR_NONE, 33'(tline_ff), 33'(tcol_ff),
                                16'd1);
                  mode_in  = MODE_IDLE;
                  do_start = 1'b1;
               end else begin
                  // A lone '&' or '|' is reported at the operator itself.
                  ea      = mk(stl_pkg::KIND_END, stl_pkg::ERR_UNSUP_OP, 33'(tline_ff),
                               33'(tcol_ff), 16'd0);
                  mode_in = MODE_FAILED;
               end
            end
            MODE_LIT: begin
               if (step_byte == delim) begin
                  ea_v = 1'b1;
                  if (!qdbl_ff && ((cnt_ff == 16'd2 && !lsb_ff) || cnt_ff > 16'd2)) begin
                     ea      = mk(stl_pkg::KIND_END, stl_pkg::ERR_CHAR_LONG, 33'(tline_ff),
                                  33'(tcol_ff), 16'd0);
                     mode_in = MODE_FAILED;
                  end else begin
                     ea      = mk(qdbl_ff ? stl_pkg::KIND_STRING : stl_pkg::KIND_CHAR,
                                  stl_pkg::ERR_NONE, 33'(tline_ff), 33'(tcol_ff), cnt_ff);
                     if (col_in != POS_MAX) col_in = col_in + 1'b1;
                     mode_in = MODE_IDLE;
                  end
               end else if (step_byte == 8'h0A) begin
                  ea_v    = 1'b1;
                  ea      = mk(stl_pkg::KIND_END, stl_pkg::ERR_NEWLINE_LIT, 33'(line_ff),
                               33'(col_ff), 16'd0);
                  mode_in = MODE_FAILED;
               end else begin
                  if (step_byte == stl_pkg::CH_BACKSLASH) begin
                     if (cnt_ff == 16'd0) lsb_in = 1'b1;
                     mode_in = MODE_ESC;
                  end
                  if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 1'b1;
                  if (col_in != POS_MAX) col_in = col_in + 1'b1;
               end
            end
            MODE_ESC: begin
               if (step_byte != delim && step_byte != 8'h0A && step_byte != 8'h6E &&
                   step_byte != 8'h74 && step_byte != stl_pkg::CH_BACKSLASH) begin
                  ea_v    = 1'b1;
                  ea      = mk(stl_pkg::KIND_END, stl_pkg::ERR_BAD_ESCAPE, 33'(line_ff),
                               33'(col_ff), 16'd0);
                  mode_in = MODE_FAILED;
               end else begin
                  if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 1'b1;
                  if (step_byte == 8'h0A) begin
                     if (line_in != POS_MAX) line_in = line_in + 1'b1;
                     col_in = '0;
                  end else if (col_in != POS_MAX) begin
                     col_in = col_in + 1'b1;
                  end
                  mode_in = MODE_LIT;
               end
            end
            default: ;
         endcase

         // Byte seen with no token open; the position has not moved before this point.
         if (do_start) begin
            case (step_byte)
               8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: begin
                  if (col_in != POS_MAX) col_in = col_in + 1'b1;
               end
               8'h0A: begin
                  if (line_in != POS_MAX) line_in = line_in + 1'b1;
                  col_in = '0;
               end
               stl_pkg::CH_COMMENT: mode_in = MODE_COMMENT;
               8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h26, 8'h7C: begin
                  tline_in = line_ff;
                  tcol_in  = col_ff;
                  pend_in  = step_byte;
                  mode_in  = MODE_OP2;
                  if (col_in != POS_MAX) col_in = col_in + 1'b1;
               end
               8'h22, 8'h27: begin
                  tline_in = line_ff;
                  tcol_in  = col_ff;
                  qdbl_in  = step_byte == 8'h22;
                  lsb_in   = 1'b0;
                  cnt_in   = '0;
                  mode_in  = MODE_LIT;
                  if (col_in != POS_MAX) col_in = col_in + 1'b1;
               end
               stl_pkg::CH_BACKSLASH, 8'h2E: begin
                  eb_v    = 1'b1;
                  eb      = mk(stl_pkg::KIND_END, stl_pkg::ERR_UNSUP_OP, 33'(line_ff),
                               33'(col_ff), 16'd0);
                  mode_in = MODE_FAILED;
               end
               default: begin
                  if (start_kind != stl_pkg::KIND_END) begin
                     eb_v = 1'b1;
                     eb   = mk(start_kind, stl_pkg::ERR_NONE, 33'(line_ff), 33'(col_ff),
                               16'd1);
                     if (col_in != POS_MAX) col_in = col_in + 1'b1;
                  end else if (is_alpha(step_byte) || is_digit(step_byte)) begin
                     tline_in  = line_ff;
                     tcol_in   = col_ff;
                     cnt_in    = 16'd1;
                     prefix_in = 40'(step_byte);
                     mode_in   = is_alpha(step_byte) ? MODE_IDENT : MODE_INT;
                     if (col_in != POS_MAX) col_in = col_in + 1'b1;
                  end else begin
                     eb_v    = 1'b1;
                     eb      = mk(stl_pkg::KIND_END, stl_pkg::ERR_BAD_CHAR, 33'(line_ff),
                                  33'(col_ff), 16'd0);
                     mode_in = MODE_FAILED;
                  end
               end
            endcase
         end
      end
   end

   // Pack the results in order and flag the final one of the step.
   always_comb begin
      res0  = ea_v ? ea : eb;
      res1  = eb;
      res_n = 2'(ea_v) + 2'(eb_v);
      if (ea_v && eb_v) begin
         res1.last_of_run = 1'b1;
      end else begin
         res0.last_of_run = 1'b1;
      end
      if (!step_valid) res_n = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= '0;
         prefix_ff <= '0;
         qdbl_ff   <= 1'b0;
         lsb_ff    <= 1'b0;
         line_ff   <= '0;
         col_ff    <= '0;
         tline_ff  <= '0;
         tcol_ff   <= '0;
         cnt_ff    <= '0;
      end else if (step_valid) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         prefix_ff <= prefix_in;
         qdbl_ff   <= qdbl_in;
         lsb_ff    <= lsb_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/stl_outq.sv */
// Result queue: takes up to two results a cycle, hands out one per response handshake.
// Depends on stl_pkg, stl_if and assert_macros.svh.
`include "assert_macros.svh"

module stl_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_n,
   input  stl_pkg::rsp_type push0,
   input  stl_pkg::rsp_type push1,
   output logic             room,
   stl_rsp_if.source        rsp
);

   stl_pkg::rsp_type                entries_ff [stl_pkg::RSP_DEPTH];
   logic [stl_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [stl_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [stl_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            pop;
   stl_pkg::rsp_type                head;

   assign pop  = rsp.valid && rsp.ready;
   // Room for a whole step's worth of results.
   assign room = count_ff <= stl_pkg::CNT_W'(stl_pkg::RSP_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + stl_pkg::PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + stl_pkg::PTR_W'(pop);
   assign count_in  = count_ff + stl_pkg::CNT_W'(push_n) - stl_pkg::CNT_W'(pop);

   assign head             = entries_ff[rd_ptr_ff];
   assign rsp.valid        = count_ff != '0;
   assign rsp.token_kind   = head.token_kind;
   assign rsp.error_code   = head.error_code;
   assign rsp.start_line   = head.start_line;
   assign rsp.start_column = head.start_column;
   assign rsp.token_length = head.token_length;
   assign rsp.last_of_run  = head.last_of_run;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) entries_ff[wr_ptr_ff] <= push0;
      if (push_n == 2'd2) entries_ff[wr_ptr_ff + stl_pkg::PTR_W'(1)] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `STL_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= stl_pkg::CNT_W'(stl_pkg::RSP_DEPTH))
   `STL_ASSERT_HOLDS(a_push_has_room, clock, reset, push_n == 2'd0 || room)
   `STL_ASSERT_HOLDS(a_push_at_most_two, clock, reset, push_n != 2'd3)
   `STL_ASSERT_NEXT(a_pop_drains, clock, reset, pop && push_n == 2'd0, $past(count_ff) == count_ff + stl_pkg::CNT_W'(1))

endmodule

/* rtl/source_token_lexer.sv */
// Source token lexer: one source byte per request, tokens out as response items.
// Throughput: one request per cycle while each byte causes at most one result and the
// queue has room for two; a byte that causes two results (token flush plus a new token,
// or a flush at end of text) takes an extra response handshake, one result per handshake.
// Reset (synchronous, active high) clears the scan state, positions and the result queue.
module source_token_lexer #(
   parameter int POS_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   stl_req_if.sink   req,
   stl_rsp_if.source rsp
);

   // Input register. It holds one request while the scanner waits for queue room, so a
   // stalled response side never loses a byte; ready stays high whenever the held byte
   // moves on in the same cycle.
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_eot_ff;

   // The scanner steps on the held byte only when the queue can absorb two results.
   logic             room;
   logic             step_fire;
   logic [1:0]       res_n;
   stl_pkg::rsp_type res0, res1;

   assign step_fire   = in_valid_ff && room;
   assign req.ready   = !in_valid_ff || step_fire;
   assign in_valid_in = (req.valid && req.ready) || (in_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload needs no reset; it is only looked at while the valid flag is set.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.text_byte;
         in_eot_ff  <= req.end_of_text;
      end
   end

   // Per-byte scan: mode, keyword prefix, line and column tracking, token assembly.
   stl_scan #(
      .POS_BITS (POS_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_fire),
      .step_byte  (in_byte_ff),
      .step_eot   (in_eot_ff),
      .res_n      (res_n),
      .res0       (res0),
      .res1       (res1)
   );

   // Result registers: a small queue that decouples the scanner from the response side.
   stl_outq u_outq (
      .clock  (clock),
      .reset  (reset),
      .push_n (res_n),
      .push0  (res0),
      .push1  (res1),
      .room   (room),
      .rsp    (rsp)
   );

endmodule
